// ----- src/deq_pkg.sv -----
// Package for the double-ended queue: payload types, codes and shared constants.
package deq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 5;

  // request codes
  localparam logic [1:0] REQ_PUSH_HEAD = 2'd0;
  localparam logic [1:0] REQ_PUSH_TAIL = 2'd1;
  localparam logic [1:0] REQ_POP_HEAD  = 2'd2;
  localparam logic [1:0] REQ_POP_TAIL  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [VALUE_W-1:0] push_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] pop_value;
    logic [1:0]                status;
    logic [COUNT_W-1:0]        count_after;
    logic                      is_empty;
  } out_beat_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic load_pop;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rd_needed;
  } dp_stat_t;

endpackage

// ----- src/deq_ram.sv -----
// Generic single-port-write, registered-read RAM.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/deq_ctrl.sv -----
// Controller: handshake, output valid and the wait state for a slot read.
module deq_ctrl
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    in_ready      = (state_r == S_IDLE) && (!out_valid_r || out_ready);
    cmd.accept    = in_valid && in_ready;
    cmd.load_pop  = 1'b0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          if (stat.rd_needed) begin
            state_nxt = S_READ;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_READ: begin
        // slot data is back from the RAM
        cmd.load_pop  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- src/deq_dp.sv -----
// Datapath: head index, count, ring address math, slot RAM and result register.
module deq_dp
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_beat_t  in_data,
  input  ctrl_cmd_t cmd,
  output dp_stat_t  stat,
  output out_beat_t out_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  out_beat_t        out_data_r;

  logic             is_push, full, empty, push_ok, pop_ok;
  logic [IDX_W-1:0] head_dec, head_inc, tail_pos;
  logic [CNT_W-1:0] offset;
  logic [SUM_W-1:0] tail_sum;
  logic [IDX_W-1:0] waddr, raddr;
  logic [1:0]       status;
  logic [VALUE_W-1:0] rdata;

  always_comb begin
    is_push  = in_data.req_type inside {REQ_PUSH_HEAD, REQ_PUSH_TAIL};
    full     = (count_r == FULL_CNT);
    empty    = (count_r == '0);
    push_ok  = is_push && !full;
    pop_ok   = !is_push && !empty;

    head_dec = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
    head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;

    // tail slot: head + count on push, head + count - 1 on pop
    offset   = is_push ? count_r : count_r - 1'b1;
    tail_sum = SUM_W'(head_r) + SUM_W'(offset);
    tail_pos = (tail_sum >= DEPTH_S) ? IDX_W'(tail_sum - DEPTH_S) : IDX_W'(tail_sum);

    waddr    = (in_data.req_type == REQ_PUSH_HEAD) ? head_dec : tail_pos;
    raddr    = (in_data.req_type == REQ_POP_HEAD)  ? head_r   : tail_pos;

    head_nxt  = head_r;
    count_nxt = count_r;
    if (push_ok) begin
      count_nxt = count_r + 1'b1;
      if (in_data.req_type == REQ_PUSH_HEAD) begin
        head_nxt = head_dec;
      end
    end else if (pop_ok) begin
      count_nxt = count_r - 1'b1;
      if (in_data.req_type == REQ_POP_HEAD) begin
        head_nxt = head_inc;
      end
    end

    if (is_push) begin
      status = full ? ST_PUSH_FULL : ST_OK;
    end else begin
      status = empty ? ST_POP_EMPTY : ST_OK;
    end

    stat.rd_needed = pop_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_data_r.pop_value   <= '0;
      out_data_r.status      <= status;
      out_data_r.count_after <= COUNT_W'(count_nxt);
      out_data_r.is_empty    <= (count_nxt == '0);
    end else if (cmd.load_pop) begin
      out_data_r.pop_value   <= rdata;
    end
  end

  deq_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (cmd.accept && push_ok),
    .waddr(waddr),
    .wdata(in_data.push_value),
    .re   (cmd.accept && pop_ok),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign out_data = out_data_r;

endmodule

// ----- src/double_ended_queue_top.sv -----
// Top level of the double-ended queue: controller, datapath and checks.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one request per beat:
//   req_type (push head, push tail, pop head, pop tail) and push_value.
//   Output channel out_valid/out_ready/out_data returns exactly one result
//   beat per request: pop_value, status, count_after and is_empty.
// Request flow:
//   Push, and a pop that finds the deque empty, update the ring in the
//   accept cycle; the result is valid the next cycle, one request a cycle
//   while out_ready drains the output. A successful pop reads its slot from
//   the registered-read slot RAM; the result register loads it in S_READ,
//   and no new request is taken until that read wait is over.
// Reset:
//   rst_n low (synchronous) empties the deque: head and count go to zero and
//   no result is pending. Slot contents are not cleared and need no pass.
// Stall:
//   The result sits in an output register until out_ready. A new request is
//   taken while that register is empty or being drained in the same cycle;
//   otherwise, and during a slot read wait, in_ready stays low.
module double_ended_queue_top
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // handshake and read wait
  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // ring pointers, slot storage, result register
  deq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .out_data(out_data)
  );

`ifndef SYNTHESIS
  // no request taken while an unread result would be overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!out_valid || out_ready))
    else $error("request accepted over a stalled result");

  // a pop that reads a slot produces its result after the read cycle
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && stat.rd_needed) |=> (!out_valid && !in_ready) ##1 out_valid)
    else $error("pop result not delivered after slot read");

  // a failed request carries a zero value
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> (out_data.pop_value == '0))
    else $error("failed request returned a value");
`endif

endmodule
